// ===== hdl/gbr_pkg.sv =====
package gbr_pkg;

    // grid side default and bounds of the queue
    localparam int GRID_SIDE_DEF = 16;
    localparam int QW            = 7;   // quotient field width, covers grid side up to 126
    localparam int QDEPTH        = 16;
    localparam int QAW           = $clog2(QDEPTH);

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_CELL_W     = 3'd2,
        CFG_CELL_H     = 3'd3,
        CFG_MARGIN     = 3'd4,
        CFG_COL_LIMIT  = 3'd5,
        CFG_ROW_LIMIT  = 3'd6,
        CFG_FLAT_TIME  = 3'd7
    } t_cfg_idx;

    // edge direction of the remainder
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_LO   = 2'd1,
        DIR_HI   = 2'd2
    } t_dir;

    // target kinds in emission order
    typedef enum logic [1:0] {
        KIND_HOME = 2'd0,
        KIND_XN   = 2'd1,
        KIND_YN   = 2'd2,
        KIND_DIAG = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] t;
    } t_point;

    // classified point: quotients are column plus one and row plus one
    typedef struct packed {
        logic [QW-1:0] colq;
        logic [QW-1:0] rowq;
        logic          xok;
        logic          yok;
        t_dir          dc;
        t_dir          dr;
    } t_route;

    typedef struct packed {
        t_route route;
        t_point pt;
    } t_entry;

    // zero cell size counts as one
    function automatic logic [23:0] eff_size(input logic [23:0] s);
        return (s == 24'd0) ? 24'd1 : s;
    endfunction

endpackage

// ===== hdl/gbr_div.sv =====
module gbr_div #(
    parameter int QB = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [33:0] i_num,
    input  logic [23:0] i_den,
    output logic        o_valid,
    output logic [QB-1:0] o_q,
    output logic [23:0] o_rem,
    output logic        o_ok
);
    logic [QB-1:0]        r_v;
    logic [33:0]          r_rem [QB];
    logic [QB-1:0]        r_q   [QB];
    logic [QB-1:0]        r_ok;
    logic [QB-1:0]        w_in_v;
    logic [33:0]          w_in_rem [QB];
    logic [QB-1:0]        w_in_q   [QB];
    logic [QB-1:0]        w_in_ok;
    logic [33:0]          w_lim;

    // numerator must be in [0, den << QB)
    assign w_lim = {10'd0, i_den} << QB;

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [33:0] w_d;
        logic        w_ge;
        if (s == 0) begin : g_first
            assign w_in_v[s]   = i_valid;
            assign w_in_rem[s] = i_num;
            assign w_in_q[s]   = '0;
            assign w_in_ok[s]  = !i_num[33] && (i_num < w_lim);
        end else begin : g_next
            assign w_in_v[s]   = r_v[s-1];
            assign w_in_rem[s] = r_rem[s-1];
            assign w_in_q[s]   = r_q[s-1];
            assign w_in_ok[s]  = r_ok[s-1];
        end
        assign w_d  = {10'd0, i_den} << (QB - 1 - s);
        assign w_ge = w_in_rem[s] >= w_d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= w_in_v[s];
            end
            r_rem[s] <= w_ge ? (w_in_rem[s] - w_d) : w_in_rem[s];
            r_q[s]   <= w_in_q[s] | (w_ge ? (QB'(1) << (QB - 1 - s)) : '0);
            r_ok[s]  <= w_in_ok[s];
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_q     = r_q[QB-1];
    assign o_rem   = r_rem[QB-1][23:0];
    assign o_ok    = r_ok[QB-1];
endmodule

// ===== hdl/gbr_front.sv =====
module gbr_front #(
    parameter int GRID_SIDE = gbr_pkg::GRID_SIDE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gbr_pkg::t_point i_pt,
    input  logic [31:0]     i_origin_x,
    input  logic [31:0]     i_origin_y,
    input  logic [23:0]     i_cell_w,
    input  logic [23:0]     i_cell_h,
    input  logic [23:0]     i_margin,
    output logic            o_valid,
    output gbr_pkg::t_entry o_entry
);
    import gbr_pkg::*;

    localparam int QB  = $clog2(GRID_SIDE + 2);
    localparam int LAT = QB + 2;

    logic [23:0]   w_cw, w_ch;
    logic          r_v0;
    logic [33:0]   r_ux, r_uy;
    t_point        r_pt [LAT];
    logic          w_dvx, w_dvy;
    logic [QB-1:0] w_qx, w_qy;
    logic [23:0]   w_rx, w_ry;
    logic          w_okx, w_oky;
    logic          r_v;
    t_route        r_route;
    t_dir          w_dc, w_dr;
    logic signed [25:0] w_hix, w_hiy;

    assign w_cw = eff_size(i_cell_w);
    assign w_ch = eff_size(i_cell_h);

    // offset from origin, shifted by one cell so column minus one stays non-negative
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
        end
        r_ux <= {{2{i_pt.x[31]}}, i_pt.x} - {{2{i_origin_x[31]}}, i_origin_x}
              + {10'd0, w_cw};
        r_uy <= {{2{i_pt.y[31]}}, i_pt.y} - {{2{i_origin_y[31]}}, i_origin_y}
              + {10'd0, w_ch};
    end

    // payload delay line matching the divider
    always_ff @(posedge i_clk) begin
        r_pt[0] <= i_pt;
        for (int k = 1; k < LAT; k++) begin
            r_pt[k] <= r_pt[k-1];
        end
    end

    gbr_div #(.QB(QB)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_num(r_ux),
        .i_den(w_cw), .o_valid(w_dvx), .o_q(w_qx), .o_rem(w_rx), .o_ok(w_okx)
    );

    gbr_div #(.QB(QB)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_num(r_uy),
        .i_den(w_ch), .o_valid(w_dvy), .o_q(w_qy), .o_rem(w_ry), .o_ok(w_oky)
    );

    // edge classification of the remainders
    assign w_hix = $signed({2'b0, w_cw}) - $signed({2'b0, i_margin});
    assign w_hiy = $signed({2'b0, w_ch}) - $signed({2'b0, i_margin});

    always_comb begin
        if (w_rx <= i_margin) begin
            w_dc = DIR_LO;
        end else if ($signed({2'b0, w_rx}) >= w_hix) begin
            w_dc = DIR_HI;
        end else begin
            w_dc = DIR_NONE;
        end
        if (w_ry <= i_margin) begin
            w_dr = DIR_LO;
        end else if ($signed({2'b0, w_ry}) >= w_hiy) begin
            w_dr = DIR_HI;
        end else begin
            w_dr = DIR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= w_dvx && w_dvy;
        end
        r_route.colq <= QW'(w_qx);
        r_route.rowq <= QW'(w_qy);
        r_route.xok  <= w_okx;
        r_route.yok  <= w_oky;
        r_route.dc   <= w_dc;
        r_route.dr   <= w_dr;
    end

    assign o_valid       = r_v;
    assign o_entry.route = r_route;
    assign o_entry.pt    = r_pt[LAT-1];
endmodule

// ===== hdl/gbr_queue.sv =====
module gbr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gbr_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_nempty,
    output gbr_pkg::t_entry o_head
);
    import gbr_pkg::*;

    t_entry         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    assign o_nempty = (r_cnt != '0);
    assign o_head   = r_mem[r_rp];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != (QAW+1)'(QDEPTH)) || i_pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nempty)
        else $error("queue underflow");
`endif
endmodule

// ===== hdl/gbr_back.sv =====
module gbr_back #(
    parameter int GRID_SIDE = gbr_pkg::GRID_SIDE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nempty,
    input  gbr_pkg::t_entry i_head,
    input  logic [4:0]      i_col_limit,
    input  logic [4:0]      i_row_limit,
    input  logic            i_flat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_bin_index,
    output logic [1:0]      o_target_kind,
    output logic [31:0]     o_out_x,
    output logic [31:0]     o_out_y,
    output logic [31:0]     o_out_z,
    output logic [31:0]     o_out_time,
    output logic            o_is_last
);
    import gbr_pkg::*;

    logic               r_valid;
    logic [3:0]         r_done;
    logic [7:0]         r_bin;
    t_kind              r_kind;
    t_point             r_pt;
    logic               r_last;
    logic signed [8:0]  w_c0, w_c1, w_r0, w_r1;
    logic               w_c0ok, w_c1ok, w_r0ok, w_r1ok;
    logic [3:0]         w_mask, w_rem;
    t_kind              w_pick;
    logic [3:0]         w_bit;
    logic               w_last;
    logic               w_free, w_emit;
    logic signed [8:0]  w_sr, w_sc;
    logic signed [15:0] w_idx;

    function automatic logic signed [8:0] step(input logic [QW-1:0] q, input t_dir d);
        logic signed [8:0] b;
        b = $signed({2'b0, q});
        case (d)
            DIR_LO:  return b - 9'sd1;
            DIR_HI:  return b + 9'sd1;
            default: return b;
        endcase
    endfunction

    function automatic logic in_range(input logic signed [8:0] v, input logic [4:0] lim);
        return (v >= 9'sd1) && (v <= 9'(GRID_SIDE)) && (v <= $signed({4'b0, lim}));
    endfunction

    // candidate columns and rows, held as index plus one
    assign w_c0 = step(i_head.route.colq, DIR_NONE);
    assign w_c1 = step(i_head.route.colq, i_head.route.dc);
    assign w_r0 = step(i_head.route.rowq, DIR_NONE);
    assign w_r1 = step(i_head.route.rowq, i_head.route.dr);
    assign w_c0ok = i_head.route.xok && in_range(w_c0, i_col_limit);
    assign w_c1ok = i_head.route.xok && (i_head.route.dc != DIR_NONE)
                  && in_range(w_c1, i_col_limit);
    assign w_r0ok = i_head.route.yok && in_range(w_r0, i_row_limit);
    assign w_r1ok = i_head.route.yok && (i_head.route.dr != DIR_NONE)
                  && in_range(w_r1, i_row_limit);

    assign w_mask = {w_r1ok && w_c1ok, w_r1ok && w_c0ok, w_r0ok && w_c1ok, w_r0ok && w_c0ok};
    assign w_rem  = w_mask & ~r_done;

    // lowest remaining target goes next
    always_comb begin
        w_pick = KIND_HOME;
        w_bit  = 4'b0001;
        if (w_rem[0]) begin
            w_pick = KIND_HOME;
            w_bit  = 4'b0001;
        end else if (w_rem[1]) begin
            w_pick = KIND_XN;
            w_bit  = 4'b0010;
        end else if (w_rem[2]) begin
            w_pick = KIND_YN;
            w_bit  = 4'b0100;
        end else begin
            w_pick = KIND_DIAG;
            w_bit  = 4'b1000;
        end
    end
    assign w_last = ((w_rem & ~w_bit) == 4'b0);

    assign w_sr  = w_pick[1] ? w_r1 : w_r0;
    assign w_sc  = w_pick[0] ? w_c1 : w_c0;
    assign w_idx = (16'(w_sr) - 16'sd1) * 16'(GRID_SIDE) + (16'(w_sc) - 16'sd1);

    assign w_free = !r_valid || i_ready;
    assign w_emit = i_nempty && w_free && (w_rem != 4'b0);
    assign o_pop  = i_nempty && w_free && ((w_rem == 4'b0) || w_last);

    // output register and progress through the head point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (w_free) begin
                r_valid <= w_emit;
            end
            if (o_pop) begin
                r_done <= '0;
            end else if (w_emit) begin
                r_done <= r_done | w_bit;
            end
        end
        if (w_emit) begin
            r_bin  <= w_idx[7:0];
            r_kind <= w_pick;
            r_pt.x <= i_head.pt.x;
            r_pt.y <= i_head.pt.y;
            r_pt.z <= i_head.pt.z;
            r_pt.t <= i_flat ? '0 : i_head.pt.t;
            r_last <= w_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_bin_index   = r_bin;
    assign o_target_kind = r_kind;
    assign o_out_x       = r_pt.x;
    assign o_out_y       = r_pt.y;
    assign o_out_z       = r_pt.z;
    assign o_out_time    = r_pt.t;
    assign o_is_last     = r_last;

`ifndef SYNTHESIS
    a_done_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != 4'b0) |-> i_nempty)
        else $error("partial point without head entry");
    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |-> o_pop)
        else $error("last word did not release head");
`endif
endmodule

// ===== hdl/grid_bin_router_with_halo_unit.sv =====
// channel  | valid   | ready   | payload
// point in | i_valid | o_ready | i_point_x, i_point_y, i_point_z, i_point_time
// bin out  | o_valid | i_ready | o_bin_index, o_target_kind, o_out_*, o_is_last
// config   | i_cfg_we| -       | i_cfg_index, i_cfg_data
//
// one point enters per cycle while o_ready is high; the back end sends one word per
// cycle unless i_ready stalls it, one word per target (one to four, or none at all)
// front: offset register, divider with one quotient bit per stage, route register
// a 16-entry queue separates front and back; input stalls when 16 points sit in
// the front pipeline and the queue together
// synchronous active-low reset clears control and loads register defaults
module grid_bin_router_with_halo_unit #(
    parameter int GRID_SIDE = gbr_pkg::GRID_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic [31:0] i_point_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_bin_index,
    output logic [1:0]  o_target_kind,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [31:0] o_out_time,
    output logic        o_is_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import gbr_pkg::*;

    logic [31:0]  r_origin_x, r_origin_y;
    logic [23:0]  r_cell_w, r_cell_h, r_margin;
    logic [4:0]   r_col_limit, r_row_limit;
    logic         r_flat;
    logic [QAW:0] r_credit;
    logic         w_acc, w_push, w_pop, w_nempty;
    t_point       w_pt;
    t_entry       w_entry, w_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_cell_w    <= 24'd256;
            r_cell_h    <= 24'd256;
            r_margin    <= '0;
            r_col_limit <= 5'd16;
            r_row_limit <= 5'd16;
            r_flat      <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin_y  <= i_cfg_data;
                CFG_CELL_W:    r_cell_w    <= i_cfg_data[23:0];
                CFG_CELL_H:    r_cell_h    <= i_cfg_data[23:0];
                CFG_MARGIN:    r_margin    <= i_cfg_data[23:0];
                CFG_COL_LIMIT: r_col_limit <= i_cfg_data[4:0];
                CFG_ROW_LIMIT: r_row_limit <= i_cfg_data[4:0];
                CFG_FLAT_TIME: r_flat      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // credits cover points in the front pipeline and in the queue
    assign o_ready = (r_credit < (QAW+1)'(QDEPTH));
    assign w_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + (QAW+1)'(w_acc) - (QAW+1)'(w_pop);
        end
    end

    assign w_pt.x = i_point_x;
    assign w_pt.y = i_point_y;
    assign w_pt.z = i_point_z;
    assign w_pt.t = i_point_time;

    gbr_front #(.GRID_SIDE(GRID_SIDE)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_acc), .i_pt(w_pt),
        .i_origin_x(r_origin_x), .i_origin_y(r_origin_y),
        .i_cell_w(r_cell_w), .i_cell_h(r_cell_h), .i_margin(r_margin),
        .o_valid(w_push), .o_entry(w_entry)
    );

    gbr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_entry(w_entry),
        .i_pop(w_pop), .o_nempty(w_nempty), .o_head(w_head)
    );

    gbr_back #(.GRID_SIDE(GRID_SIDE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_nempty(w_nempty), .i_head(w_head),
        .i_col_limit(r_col_limit), .i_row_limit(r_row_limit), .i_flat(r_flat),
        .o_pop(w_pop), .o_valid(o_valid), .i_ready(i_ready),
        .o_bin_index(o_bin_index), .o_target_kind(o_target_kind),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_out_time(o_out_time), .o_is_last(o_is_last)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= (QAW+1)'(QDEPTH))
        else $error("credit count above queue depth");
    a_pop_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_credit != '0))
        else $error("pop without outstanding point");
`endif
endmodule
